[sv/lru_key_value_cache_top_macros.svh]
// Assertion macros shared by the LRU key/value cache RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every edge out of reset.
`define LKVC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LKVC_ASSERT_ALWAYS(lbl, prop, msg)
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/lkvc_pkg.sv]
// Package for the LRU key/value cache: field widths, opcodes, entry type.
// No dependencies; used by lkvc_cell and lru_key_value_cache_top.
package lkvc_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lkvc_entry_t;

endpackage

[sv/lkvc_cell.sv]
// One cell of the recency-ordered chain: holds one entry, compares its key.
// Depends on lkvc_pkg.
module lkvc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift_en,
    input  lkvc_pkg::lkvc_entry_t      nbr_in,
    input  logic [lkvc_pkg::KEY_W-1:0] lookup_key,
    output lkvc_pkg::lkvc_entry_t      entry,
    output logic                       match
);
    import lkvc_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    // valid is control state, key/value are payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= nbr_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg   <= nbr_in.key;
            value_reg <= nbr_in.value;
        end
    end

    assign match = valid_reg && (key_reg == lookup_key);

    always_comb
    begin
        entry.valid = valid_reg;
        entry.key   = key_reg;
        entry.value = value_reg;
    end

endmodule

[sv/lru_key_value_cache_top.sv]
// Top level of the LRU key/value cache: a chain of entry cells kept in
// recency order, plus lookup, replacement control and the result register.
// Depends on lkvc_pkg, lkvc_cell and lru_key_value_cache_top_macros.svh.
//
//  channel | signals                           | direction | width of payload
//  --------+-----------------------------------+-----------+-----------------
//  input   | in_valid, in_stall, op/key/value  | in        | 1 + 32 + 32
//  result  | out_valid, out_stall, hit,        | out       | 1 + 32 + 1 + 32
//          |   read_value, evicted, evicted_key|           |
//  config  | cfg_we, cfg_wdata (capacity)      | in        | 5
//
// Cycles: one transaction per cycle sustained while in_stall is low. The key compare across all
//   cells, the recency shift and the result register update all happen in
//   the cycle an input transaction is accepted; the result shows in the next cycle.
// Cell 0 is the most recent entry; valid cells always form a prefix of the
//   chain, so the tail cell is the least recent and is the one evicted.
// A hit at cell p shifts cells 0..p-1 down by one and reloads cell 0.
// Reset clears every valid bit and the fill count, and sets capacity back to 16.
// in_stall is high only while a result is held and out_stall is high.
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [lkvc_pkg::KEY_W-1:0] key,
    input  logic [lkvc_pkg::VAL_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [lkvc_pkg::VAL_W-1:0] read_value,
    output logic                       evicted,
    output logic [lkvc_pkg::KEY_W-1:0] evicted_key
);
    import lkvc_pkg::*;

`include "lru_key_value_cache_top_macros.svh"

    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = (UW > CAP_W) ? UW : CAP_W;

    // Chain state views
    lkvc_entry_t      cell_q   [ENTRIES];
    lkvc_entry_t      cell_in  [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] shift_vec;
    logic [ENTRIES:0]   hit_at_or_after;  // prefix OR of matches from the tail
    logic [ENTRIES-1:0] used_mask;

    // Control registers
    logic [CAP_W-1:0] cap_reg;
    logic [UW-1:0]    used_reg, used_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic             evicted_reg;
    logic [KEY_W-1:0] evicted_key_reg;

    logic             accept;
    logic             is_put;
    logic             hit_any;
    logic             do_evict;
    logic [CW-1:0]    eff_cap;
    logic [VAL_W-1:0] sel_value;
    logic [KEY_W-1:0] tail_key;
    lkvc_entry_t      head_entry;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_put   = (op_t'(op) == OP_PUT);

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign cell_in[gi] = head_entry;
            end
            else
            begin : g_body
                assign cell_in[gi] = cell_q[gi-1];
            end

            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (shift_vec[gi]),
                .nbr_in     (cell_in[gi]),
                .lookup_key (key),
                .entry      (cell_q[gi]),
                .match      (match_vec[gi])
            );

            assign valid_vec[gi]       = cell_q[gi].valid;
            assign hit_at_or_after[gi] = match_vec[gi] || hit_at_or_after[gi+1];
        end
    endgenerate

    assign hit_at_or_after[ENTRIES] = 1'b0;
    assign hit_any                  = hit_at_or_after[0];

    // Capacity clamped into 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(cap_reg) > CW'(ENTRIES))
        begin
            eff_cap = CW'(ENTRIES);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign do_evict = is_put && !hit_any && (CW'(used_reg) >= eff_cap);

    // Hit value and tail key: keys are unique, so at most one match
    always_comb
    begin
        sel_value = '0;
        tail_key  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                sel_value = sel_value | cell_q[i].value;
            end
            if (valid_vec[i] && ((i == ENTRIES - 1) || !valid_vec[(i + 1) % ENTRIES]))
            begin
                tail_key = tail_key | cell_q[i].key;
            end
        end
    end

    // New most-recent entry
    always_comb
    begin
        head_entry.valid = 1'b1;
        head_entry.key   = key;
        head_entry.value = is_put ? value : sel_value;
    end

    // Shift enables: up to the hit, or over the used span (and one cell past it if no eviction) on a put miss
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!accept)
            begin
                shift_vec[i] = 1'b0;
            end
            else if (hit_any)
            begin
                shift_vec[i] = hit_at_or_after[i];
            end
            else if (!is_put)
            begin
                shift_vec[i] = 1'b0;
            end
            else if (do_evict)
            begin
                shift_vec[i] = valid_vec[i];
            end
            else
            begin
                shift_vec[i] = (i == 0) || valid_vec[i] || valid_vec[(i + ENTRIES - 1) % ENTRIES];
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (accept && is_put && !hit_any && !do_evict)
        begin
            used_next = used_reg + UW'(1);
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only when a transaction is accepted
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg         <= hit_any;
            read_value_reg  <= is_put ? '0 : (hit_any ? sel_value : MISS_VALUE);
            evicted_reg     <= do_evict;
            evicted_key_reg <= do_evict ? tail_key : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            used_mask[i] = (UW'(i) < used_reg);
        end
    end

    `LKVC_ASSERT_ALWAYS(a_valid_prefix, valid_vec == used_mask, "valid cells not a prefix of fill count")
    `LKVC_ASSERT_ALWAYS(a_single_match, $onehot0(match_vec), "duplicate key held in cache")
    `LKVC_ASSERT_ALWAYS(a_evict_no_hit, !(out_valid_reg && evicted_reg && hit_reg), "eviction reported on a hit")
    `LKVC_ASSERT_NEXT(a_put_to_head, accept && is_put, cell_q[0].valid && (cell_q[0].key == $past(key)), "put key not at head")

endmodule
